FILE: rtl/brsq_pkg.sv
// shared types and constants for the block range sum query engine
// no dependencies; used by block_range_sum_query and its testbench
package brsq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_BLOCKS   = 64;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;   // element index
  localparam int CNT_W     = 11;   // element count, holds MAX_ELEMENTS itself
  localparam int SPAN_W    = 12;   // index plus block length without overflow
  localparam int LEN_W     = 7;    // block length register
  localparam int BLK_W     = 6;    // block sum store address
  localparam int DIV_CNT_W = 4;    // divider step counter
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN     = 1'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [CNT_W-1:0] ELEMENT_COUNT_RST = 11'd1024;
  localparam logic [LEN_W-1:0] BLOCK_LEN_RST     = 7'd33;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] value;
    logic [9:0]         left;
    logic [9:0]         right;
  } req_t;

  typedef struct packed {
    logic signed [31:0] sum;
    logic               status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/block_range_sum_query.sv
// range sum engine over a block-decomposed element store
// depends on brsq_pkg (types, constants, state encoding)
//
// usage:
//   cfg port: write element_count (index 0) and block_len (index 1) while idle.
//   req channel (req_valid/req_stall/req): a load word appends one element and
//   adds it into its block sum; a query word asks for the sum over [left, right].
//   rsp channel (rsp_valid/rsp_stall/rsp): one word per query, none per load.
//   one word is in work at a time; req_stall is high while it is.
//   load: a 10-step quotient of index by block length, then a read-modify-write of
//   the block sum.
//   query: accept, the 10-step divider, then the walk with one memory read per
//   cycle (one element or one block sum; up to two partial blocks plus the whole
//   blocks in the block sum store between), then the drain and finish states,
//   which register the result; at most 93 reads for 1024 elements and block length 33.
//   an empty or out-of-range query skips the divider and the walk.
//   reset clears the state, the result valid flag, the loaded count and the block
//   sum valid bits, so block sums read as zero; no clearing pass is needed.
//   a stalled result stays in the output register; the engine still takes the
//   next word and only waits at the end of a later query if that register is full.
module block_range_sum_query (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [brsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brsq_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  brsq_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output brsq_pkg::rsp_t                     rsp
);

  brsq_pkg::state_t state, state_next;

  logic [brsq_pkg::CNT_W-1:0]  element_count;
  logic [brsq_pkg::LEN_W-1:0]  block_len;
  logic [brsq_pkg::CNT_W-1:0]  loaded_count;
  logic [brsq_pkg::CNT_W-1:0]  eff_count;
  logic [brsq_pkg::LEN_W-1:0]  len_eff;

  // item registers
  logic                         is_load;
  logic [brsq_pkg::DATA_W-1:0]  load_value;
  logic [brsq_pkg::IDX_W-1:0]   right_q;
  logic [brsq_pkg::LEN_W-1:0]   len_q;

  // divider, then block counter and offset of the walk
  logic [brsq_pkg::IDX_W-1:0]     div_quo;
  logic [brsq_pkg::LEN_W-1:0]     div_rem;
  logic [brsq_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [brsq_pkg::LEN_W:0]       div_shift;
  logic                           div_ge;

  logic [brsq_pkg::CNT_W-1:0]   walk_i;
  logic [brsq_pkg::DATA_W-1:0]  acc;
  logic                         status_q;
  logic                         pend;
  logic                         pend_blk;

  // memories
  logic [brsq_pkg::DATA_W-1:0]  elem_mem [brsq_pkg::MAX_ELEMENTS];
  logic [brsq_pkg::DATA_W-1:0]  bsum_mem [brsq_pkg::MAX_BLOCKS];
  logic [brsq_pkg::MAX_BLOCKS-1:0] bsum_valid;
  logic                         bvalid_q;
  logic [brsq_pkg::DATA_W-1:0]  elem_rdata;
  logic [brsq_pkg::DATA_W-1:0]  bsum_rdata;
  logic [brsq_pkg::DATA_W-1:0]  bsum_data;
  logic [brsq_pkg::BLK_W-1:0]   blk_addr;
  logic                         blk_in_store;

  // control
  logic accept;
  logic elem_we, elem_re, bsum_re, bsum_we;
  logic walk_more, take_blk, blk_end, rsp_load;

  assign eff_count = (element_count > brsq_pkg::CNT_W'(brsq_pkg::MAX_ELEMENTS))
                     ? brsq_pkg::CNT_W'(brsq_pkg::MAX_ELEMENTS) : element_count;
  assign len_eff   = (block_len == '0) ? brsq_pkg::LEN_W'(1) : block_len;

  assign req_stall = (state != brsq_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;

  assign blk_addr     = div_quo[brsq_pkg::BLK_W-1:0];
  assign blk_in_store = (div_quo < brsq_pkg::IDX_W'(brsq_pkg::MAX_BLOCKS));
  assign bsum_data    = bvalid_q ? bsum_rdata : '0;

  // one restoring division step
  assign div_shift = {div_rem, div_quo[brsq_pkg::IDX_W-1]};
  assign div_ge    = (div_shift >= {1'b0, len_q});

  assign walk_more = ({1'b0, right_q} >= walk_i);
  // whole block inside the range and the store: starts at a block boundary and ends by right
  assign take_blk  = (div_rem == '0) && blk_in_store &&
                     ((brsq_pkg::SPAN_W'(walk_i) + brsq_pkg::SPAN_W'(len_q)) <=
                      (brsq_pkg::SPAN_W'(right_q) + brsq_pkg::SPAN_W'(1)));
  assign blk_end   = (div_rem == len_q - brsq_pkg::LEN_W'(1));

  always_comb begin
    state_next = state;
    elem_we    = 1'b0;
    elem_re    = 1'b0;
    bsum_re    = 1'b0;
    bsum_we    = 1'b0;
    rsp_load   = 1'b0;
    case (state)
      brsq_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.req_type == brsq_pkg::REQ_LOAD) begin
            if (loaded_count < eff_count) state_next = brsq_pkg::ST_DIV;
          end else if (req.left > req.right) begin
            state_next = brsq_pkg::ST_FINISH;
          end else if ({1'b0, req.right} >= loaded_count) begin
            state_next = brsq_pkg::ST_FINISH;
          end else begin
            state_next = brsq_pkg::ST_DIV;
          end
        end
      end
      brsq_pkg::ST_DIV: begin
        if (div_cnt == brsq_pkg::DIV_CNT_W'(brsq_pkg::IDX_W - 1)) begin
          state_next = is_load ? brsq_pkg::ST_LOAD_RD : brsq_pkg::ST_WALK;
        end
      end
      brsq_pkg::ST_LOAD_RD: begin
        elem_we    = 1'b1;
        bsum_re    = blk_in_store;
        state_next = brsq_pkg::ST_LOAD_WR;
      end
      brsq_pkg::ST_LOAD_WR: begin
        bsum_we    = blk_in_store;
        state_next = brsq_pkg::ST_IDLE;
      end
      brsq_pkg::ST_WALK: begin
        if (walk_more) begin
          bsum_re = take_blk;
          elem_re = !take_blk;
        end else begin
          state_next = brsq_pkg::ST_DRAIN;
        end
      end
      brsq_pkg::ST_DRAIN: begin
        state_next = brsq_pkg::ST_FINISH;
      end
      brsq_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = brsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= brsq_pkg::ELEMENT_COUNT_RST;
      block_len     <= brsq_pkg::BLOCK_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        brsq_pkg::CFG_ELEMENT_COUNT: element_count <= cfg_data;
        brsq_pkg::CFG_BLOCK_LEN:     block_len     <= cfg_data[brsq_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
      bsum_valid   <= '0;
      bvalid_q     <= 1'b0;
    end else begin
      if (elem_we) loaded_count <= loaded_count + brsq_pkg::CNT_W'(1);
      pend <= elem_re || bsum_re && (state == brsq_pkg::ST_WALK);
      if (bsum_re) bvalid_q <= bsum_valid[blk_addr];
      if (bsum_we) bsum_valid[blk_addr] <= 1'b1;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_load    <= (req.req_type == brsq_pkg::REQ_LOAD);
      load_value <= req.value;
      right_q    <= req.right;
      len_q      <= len_eff;
      div_rem    <= '0;
      div_cnt    <= '0;
      walk_i     <= brsq_pkg::CNT_W'(req.left);
      div_quo    <= (req.req_type == brsq_pkg::REQ_LOAD)
                    ? loaded_count[brsq_pkg::IDX_W-1:0] : req.left;
      status_q   <= (req.req_type == brsq_pkg::REQ_QUERY) && (req.left <= req.right) &&
                    ({1'b0, req.right} >= loaded_count)
                    ? brsq_pkg::STATUS_RANGE : brsq_pkg::STATUS_OK;
    end else if (state == brsq_pkg::ST_DIV) begin
      div_cnt <= div_cnt + brsq_pkg::DIV_CNT_W'(1);
      div_quo <= {div_quo[brsq_pkg::IDX_W-2:0], div_ge};
      div_rem <= div_ge ? brsq_pkg::LEN_W'(div_shift - {1'b0, len_q})
                        : div_shift[brsq_pkg::LEN_W-1:0];
    end else if (state == brsq_pkg::ST_WALK && walk_more) begin
      if (take_blk) begin
        walk_i  <= walk_i + brsq_pkg::CNT_W'(len_q);
        div_quo <= div_quo + brsq_pkg::IDX_W'(1);
      end else begin
        walk_i <= walk_i + brsq_pkg::CNT_W'(1);
        if (blk_end) begin
          div_rem <= '0;
          div_quo <= div_quo + brsq_pkg::IDX_W'(1);
        end else begin
          div_rem <= div_rem + brsq_pkg::LEN_W'(1);
        end
      end
    end

    // accumulator: cleared per query, takes last cycle's read
    if (accept) begin
      acc <= '0;
    end else if (pend) begin
      acc <= acc + (pend_blk ? bsum_data : elem_rdata);
    end
    if (elem_re || bsum_re) pend_blk <= bsum_re;

    if (rsp_load) begin
      rsp.sum    <= acc;
      rsp.status <= status_q;
    end
  end

  // element store
  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[loaded_count[brsq_pkg::IDX_W-1:0]] <= load_value;
    if (elem_re) elem_rdata <= elem_mem[walk_i[brsq_pkg::IDX_W-1:0]];
  end

  // block sum store, read-modify-write on load
  always_ff @(posedge clk) begin
    if (bsum_we) bsum_mem[blk_addr] <= bsum_data + load_value;
    if (bsum_re) bsum_rdata <= bsum_mem[blk_addr];
  end

`ifndef ASSERT_OFF
  a_pend_after_walk: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(state == brsq_pkg::ST_WALK))
    else $error("read data pending outside the walk");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= brsq_pkg::CNT_W'(brsq_pkg::MAX_ELEMENTS))
    else $error("loaded count beyond capacity");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    (state == brsq_pkg::ST_WALK) |-> (div_rem < len_q))
    else $error("block offset not below block length");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == brsq_pkg::STATUS_RANGE) |-> (rsp.sum == '0))
    else $error("flagged query with nonzero sum");

  a_blk_read_in_store: assert property (@(posedge clk) disable iff (rst)
    bsum_re |-> blk_in_store)
    else $error("block sum read past the store");
`endif

endmodule

FILE: test/tb_block_range_sum_query.sv
// self-checking testbench for block_range_sum_query: loads and range queries with random
// gaps and stalls, checked word by word against a local range-sum predictor
// depends on brsq_pkg and the block_range_sum_query rtl
module tb_block_range_sum_query;

  class range_sum_scoreboard;
    logic [brsq_pkg::DATA_W-1:0] elements [brsq_pkg::MAX_ELEMENTS];
    logic [brsq_pkg::DATA_W-1:0] block_sums [brsq_pkg::MAX_BLOCKS];
    int unsigned loaded;
    int unsigned count_reg;
    int unsigned len_reg;
    brsq_pkg::rsp_t expected_sums [$];
    int errors;

    function new();
      foreach (block_sums[b]) block_sums[b] = '0;
      loaded = 0;
      count_reg = 32'(brsq_pkg::ELEMENT_COUNT_RST);
      len_reg = 32'(brsq_pkg::BLOCK_LEN_RST);
      errors = 0;
    endfunction

    function void write_reg(logic [brsq_pkg::CFG_IDX_W-1:0] idx,
                            logic [brsq_pkg::CFG_W-1:0] data);
      if (idx == brsq_pkg::CFG_ELEMENT_COUNT) begin
        count_reg = 32'(data);
      end else if (idx == brsq_pkg::CFG_BLOCK_LEN) begin
        len_reg = 32'(data[brsq_pkg::LEN_W-1:0]);
      end
    endfunction

    function int unsigned eff_len();
      return (len_reg == 0) ? 1 : len_reg;
    endfunction

    function int unsigned eff_count();
      return (count_reg > brsq_pkg::MAX_ELEMENTS) ? brsq_pkg::MAX_ELEMENTS : count_reg;
    endfunction

    function brsq_pkg::rsp_t predict_range_sum(int unsigned l, int unsigned r);
      brsq_pkg::rsp_t res;
      int unsigned len;
      int unsigned i;
      logic [brsq_pkg::DATA_W-1:0] acc;
      res.sum = '0;
      res.status = brsq_pkg::STATUS_OK;
      if (l > r) return res;
      if (r >= loaded) begin
        res.status = brsq_pkg::STATUS_RANGE;
        return res;
      end
      len = eff_len();
      acc = '0;
      i = l;
      // whole blocks come from the stored sums, even if stale after a length change
      while (i <= r) begin
        if ((i % len) == 0 && i + len - 1 <= r && (i / len) < brsq_pkg::MAX_BLOCKS) begin
          acc += block_sums[i / len];
          i += len;
        end else begin
          acc += elements[i];
          i++;
        end
      end
      res.sum = acc;
      return res;
    endfunction

    function void note_word(brsq_pkg::req_t w);
      int unsigned blk;
      if (w.req_type == brsq_pkg::REQ_QUERY) begin
        expected_sums.push_back(predict_range_sum(32'(w.left), 32'(w.right)));
        return;
      end
      if (loaded >= eff_count()) return;
      elements[loaded] = w.value;
      blk = loaded / eff_len();
      if (blk < brsq_pkg::MAX_BLOCKS) block_sums[blk] += w.value;
      loaded++;
    endfunction

    function void check_word(brsq_pkg::rsp_t got);
      brsq_pkg::rsp_t want;
      if (expected_sums.size() == 0) begin
        $error("result word with none expected: sum %0d status %0d", got.sum, got.status);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      if (got.sum !== want.sum) begin
        $error("sum: expected %0d, actual %0d", want.sum, got.sum);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [brsq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [brsq_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  brsq_pkg::req_t                 req = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  brsq_pkg::rsp_t                 rsp;

  range_sum_scoreboard board = new();
  int rsp_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  block_range_sum_query i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: check accepted words, random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        board.check_word(rsp);
        rsp_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (rsp_seen == 40 && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      rsp_stall <= (hold_left > 0) ||
                   (!(rsp_seen >= 80 && rsp_seen < 130) && $urandom_range(0, 99) < 14);
    end
  end

  function automatic brsq_pkg::req_t load_word(logic [brsq_pkg::DATA_W-1:0] v);
    brsq_pkg::req_t w;
    w = '0;
    w.req_type = brsq_pkg::REQ_LOAD;
    w.value = v;
    w.left = brsq_pkg::IDX_W'($urandom);
    w.right = brsq_pkg::IDX_W'($urandom);
    return w;
  endfunction

  function automatic brsq_pkg::req_t query_word(int unsigned l, int unsigned r);
    brsq_pkg::req_t w;
    w.req_type = brsq_pkg::REQ_QUERY;
    w.value = $urandom;
    w.left = brsq_pkg::IDX_W'(l);
    w.right = brsq_pkg::IDX_W'(r);
    return w;
  endfunction

  function automatic logic [brsq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic brsq_pkg::req_t pick_query();
    int unsigned l;
    int unsigned r;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (board.loaded == 0 || pick < 10) begin
      l = $urandom_range(0, 1023);
      r = $urandom_range(0, 1023);
    end else if (pick < 20) begin
      r = $urandom_range(0, 1022);
      l = $urandom_range(r + 1, 1023);
    end else begin
      r = $urandom_range(0, board.loaded - 1);
      l = $urandom_range(0, r);
      // start some ranges on a block boundary so whole blocks get used
      if (pick < 50) begin
        len = board.eff_len();
        l = (l / len) * len;
      end
    end
    return query_word(l, r);
  endfunction

  task automatic push_word(input brsq_pkg::req_t w, input bit may_idle);
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    board.note_word(w);
    if (may_idle && $urandom_range(0, 99) < 14) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // drain all results, then give a trailing load time to finish
  task automatic settle();
    req_valid <= 1'b0;
    while (board.expected_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apply_config(input logic [brsq_pkg::CFG_W-1:0] count,
                              input logic [brsq_pkg::CFG_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_index <= brsq_pkg::CFG_ELEMENT_COUNT;
    cfg_data <= count;
    @(posedge clk);
    cfg_index <= brsq_pkg::CFG_BLOCK_LEN;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(brsq_pkg::CFG_ELEMENT_COUNT, count);
    board.write_reg(brsq_pkg::CFG_BLOCK_LEN, len);
  endtask

  task automatic run_random(input int n, input bit may_idle);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        push_word(load_word(pick_value()), may_idle);
      end else begin
        push_word(pick_query(), may_idle);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count above capacity and zero block length
    apply_config(11'd2047, 11'd0);
    push_word(load_word(32'h8000_0000), 1'b1);
    push_word(load_word(32'h7fff_ffff), 1'b1);
    push_word(load_word(32'hffff_ffff), 1'b1);
    push_word(load_word(32'h0000_0000), 1'b1);
    push_word(load_word(32'h0000_0001), 1'b1);
    push_word(load_word(32'h5555_5555), 1'b1);
    push_word(query_word(0, 0), 1'b1);
    push_word(query_word(0, 5), 1'b1);
    push_word(query_word(5, 5), 1'b1);
    push_word(query_word(2, 4), 1'b1);
    push_word(query_word(4, 1), 1'b1);
    push_word(query_word(1023, 0), 1'b1);
    push_word(query_word(0, 6), 1'b1);
    push_word(query_word(1023, 1023), 1'b1);
    settle();

    // block length changed after loads: stored sums stay as accumulated
    apply_config(11'd2047, 11'd3);
    push_word(query_word(0, 5), 1'b1);
    push_word(query_word(3, 5), 1'b1);
    push_word(query_word(1, 5), 1'b1);
    settle();

    // count below what is loaded: loads are dropped
    apply_config(11'd1, 11'd3);
    push_word(load_word(32'haaaa_aaaa), 1'b1);
    push_word(query_word(0, 5), 1'b1);
    settle();

    apply_config(11'd1024, 11'd1);
    run_random(100, 1'b1);
    settle();
    apply_config(11'd1024, 11'd127);
    run_random(100, 1'b0);
    settle();
    apply_config(11'd1024, 11'd64);
    run_random(100, 1'b1);
    settle();
    apply_config(11'd1024, 11'd17);
    run_random(100, 1'b1);
    settle();

    if (board.errors == 0 && board.expected_sums.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: block_range_sum_query.f
rtl/brsq_pkg.sv
rtl/block_range_sum_query.sv
test/tb_block_range_sum_query.sv
